>>> hw/rtl/msfe_pkg.sv
package msfe_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int PRICE_BITS  = 32;
    localparam int COUNT_BITS  = 11;
    localparam int SOLD_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        STAT_SOLD   = 2'd0,
        STAT_NONE   = 2'd1,
        STAT_LOADED = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

endpackage

>>> hw/rtl/multiset_floor_extract_top.sv
// A result is registered once its item has been accepted, the whole table has been scanned
// and the output register is free. No new item is taken until that result is committed;
// the scan compares one table entry per cycle through the registered read port of the
// price and count memories. Reset: aresetn is synchronous, active low. After reset a
// clearing pass zeroes every count memory entry, one per cycle, before s_tready rises.
module multiset_floor_extract_top
    import msfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] ticket_price, [63:32] max_price
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sold_price
    output logic [1:0]  m_tuser    // [1:0] status
);

    // ---------------------------------------------------------------
    // Table storage: prices (undefined until written) and copy counts
    // ---------------------------------------------------------------
    price_t price_mem [TABLE_DEPTH];
    count_t count_mem [TABLE_DEPTH];

    // Control state
    state_t                state_reg,   state_next;
    logic [IDX_BITS:0]     scan_cnt_reg, scan_cnt_next;   // 0..TABLE_DEPTH
    idx_t                  clr_idx_reg, clr_idx_next;
    mode_t                 mode_reg,    mode_next;
    price_t                key_reg,     key_next;

    // Scan results: matching (load) or best floor (query) entry, first free entry
    logic                  hit_reg,       hit_next;
    idx_t                  hit_idx_reg,   hit_idx_next;
    count_t                hit_cnt_reg,   hit_cnt_next;
    price_t                hit_price_reg, hit_price_next;
    logic                  free_reg,      free_next;
    idx_t                  free_idx_reg,  free_idx_next;

    // Output register
    logic                  m_valid_reg,  m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [SOLD_BITS-1:0]  m_sold_reg,   m_sold_next;

    // Memory ports
    idx_t                  rd_addr;
    price_t                rd_price_reg;
    count_t                rd_count_reg;
    idx_t                  cmp_idx;
    logic                  cmp_valid;
    logic                  cnt_we;
    idx_t                  cnt_waddr;
    count_t                cnt_wdata;
    logic                  price_we;

    logic                  s_fire;
    logic                  out_free;
    logic                  live;

    assign rd_addr   = scan_cnt_reg[IDX_BITS-1:0];
    assign cmp_idx   = rd_addr - idx_t'(1);          // entry whose data arrives this cycle
    assign cmp_valid = (state_reg == ST_SCAN) && (scan_cnt_reg != '0);
    assign live      = (rd_count_reg != '0);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_sold_reg;
    assign m_tuser   = m_status_reg;

    // Memories: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        rd_count_reg <= count_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (price_we) begin
            price_mem[free_idx_reg] <= key_reg;
        end
        rd_price_reg <= price_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        clr_idx_next   = clr_idx_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        hit_price_next = hit_price_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_sold_next    = m_sold_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = clr_idx_reg;
        cnt_wdata      = '0;
        price_we       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we       = 1'b1;
                clr_idx_next = clr_idx_reg + idx_t'(1);
                if (clr_idx_reg == idx_t'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    mode_next     = mode_t'(s_tuser);
                    key_next      = s_tuser ? s_tdata[63:32] : s_tdata[31:0];
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // equality for loads, floor search for queries
                if (cmp_valid) begin
                    if (mode_reg == MODE_LOAD) begin
                        if (live && rd_price_reg == key_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = cmp_idx;
                            hit_cnt_next = rd_count_reg;
                        end else if (!live && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = cmp_idx;
                        end
                    end else begin
                        if (live && rd_price_reg <= key_reg &&
                            (!hit_reg || rd_price_reg > hit_price_reg)) begin
                            hit_next       = 1'b1;
                            hit_idx_next   = cmp_idx;
                            hit_cnt_next   = rd_count_reg;
                            hit_price_next = rd_price_reg;
                        end
                    end
                end
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == (IDX_BITS+1)'(TABLE_DEPTH)) begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE: begin
                // commit only once the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sold_next  = '0;
                    state_next   = ST_IDLE;
                    cnt_waddr    = hit_idx_reg;
                    if (mode_reg == MODE_LOAD) begin
                        if (hit_reg) begin
                            if (hit_cnt_reg == COUNT_MAX) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                cnt_we        = 1'b1;
                                cnt_wdata     = hit_cnt_reg + count_t'(1);
                                m_status_next = STAT_LOADED;
                            end
                        end else if (free_reg) begin
                            cnt_we        = 1'b1;
                            cnt_waddr     = free_idx_reg;
                            cnt_wdata     = count_t'(1);
                            price_we      = 1'b1;
                            m_status_next = STAT_LOADED;
                        end else begin
                            m_status_next = STAT_FULL;
                        end
                    end else begin
                        if (hit_reg) begin
                            cnt_we        = 1'b1;
                            cnt_wdata     = hit_cnt_reg - count_t'(1);
                            m_status_next = STAT_SOLD;
                            m_sold_next   = SOLD_BITS'(hit_price_reg);
                        end else begin
                            m_status_next = STAT_NONE;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg  <= scan_cnt_next;
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_cnt_reg   <= hit_cnt_next;
        hit_price_reg <= hit_price_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        m_status_reg  <= m_status_next;
        m_sold_reg    <= m_sold_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // no item taken while the count memory is still being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("item accepted during clearing pass");

    // a floor hit never exceeds the query limit
    a_floor_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && mode_reg == MODE_QUERY && hit_reg) |->
            (hit_price_reg <= key_reg))
        else $error("floor entry above limit");

    // a matched or chosen entry is always live
    a_hit_is_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && hit_reg) |-> (hit_cnt_reg != '0))
        else $error("selected entry has zero count");

    // sold price is zero unless a ticket was sold
    a_sold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_SOLD) |-> (m_sold_reg == '0))
        else $error("nonzero sold price without a sale");

    // a result is only produced by the commit step
    a_result_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_WRITE))
        else $error("result raised outside commit");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench
    import msfe_pkg::*;
;

    // One scan per item: a result lags its item by the full table sweep plus the
    // registered memory read and the commit step.
    localparam int SCAN_LATENCY   = TABLE_DEPTH + 3;
    localparam int RANDOM_ORDERS  = 580;
    localparam int HOLD_CYCLES    = 6000;
    localparam int HOLD_AT_RESULT = 120;
    // Longest quiet stretch seen in a correct run is the receiver hold-off plus one scan
    // (or the clearing pass after reset); allow the hold-off plus sixteen scans.
    localparam int WATCHDOG_LIMIT = HOLD_CYCLES + 16 * SCAN_LATENCY;
    localparam int IDLE_PCT       = 11;

    // One ticket order as it travels on the input stream.
    typedef struct packed {
        mode_t  mode;
        price_t ticket;   // used on loads
        price_t limit;    // used on queries
    } order_t;

    // One result as it travels on the output stream.
    typedef struct packed {
        status_t               status;
        logic [SOLD_BITS-1:0]  sold;
    } sale_t;

    logic        aclk;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] ticket_price, [63:32] max_price
    logic        s_tuser  = 1'b0; // [0] mode

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] sold_price
    logic [1:0]  m_tuser;         // [1:0] status

    multiset_floor_extract_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Ticket ledger: our own copy of the multiset, updated as items are
    // accepted. An entry is live while its count is nonzero.
    // ------------------------------------------------------------------
    price_t ledger_price [TABLE_DEPTH];
    count_t ledger_count [TABLE_DEPTH];
    int     live_entries;
    int     peak_live;

    order_t order_queue [$];     // items not yet offered
    sale_t  pending_sales [$];   // expected results, oldest first

    int items_in;
    int results_out;
    int mismatches;
    int load_items;
    int query_items;
    int status_seen [4];
    int total_orders;

    // Add one copy: bump an equal live entry, else take the lowest free one.
    function automatic sale_t book_ticket(price_t p);
        sale_t r;
        int    i;
        int    free_slot;
        bit    have_free;
        r.sold    = '0;
        r.status  = STAT_LOADED;
        free_slot = 0;
        have_free = 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (ledger_count[i] != '0) begin
                if (ledger_price[i] == p) begin
                    if (ledger_count[i] == COUNT_MAX) begin
                        r.status = STAT_FULL;
                    end else begin
                        ledger_count[i] = ledger_count[i] + 1'b1;
                    end
                    return r;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = i;
            end
        end
        if (!have_free) begin
            r.status = STAT_FULL;
            return r;
        end
        ledger_price[free_slot] = p;
        ledger_count[free_slot] = count_t'(1);
        live_entries++;
        if (live_entries > peak_live) begin
            peak_live = live_entries;
        end
        return r;
    endfunction

    // Greatest live price not above the limit; remove one copy of it.
    function automatic sale_t sell_floor(price_t lim);
        sale_t r;
        int    i;
        int    best;
        bit    found;
        best  = 0;
        found = 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (ledger_count[i] != '0 && ledger_price[i] <= lim) begin
                if (!found || ledger_price[i] > ledger_price[best]) begin
                    found = 1'b1;
                    best  = i;
                end
            end
        end
        if (!found) begin
            r.status = STAT_NONE;
            r.sold   = '0;
            return r;
        end
        r.status = STAT_SOLD;
        r.sold   = ledger_price[best];
        ledger_count[best] = ledger_count[best] - 1'b1;
        if (ledger_count[best] == '0) begin
            live_entries--;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Queue one order; the field the block ignores carries random noise so that
    // every input bit toggles.
    task automatic push_order(input mode_t m, input price_t v);
        order_t o;
        o.mode   = m;
        o.ticket = (m == MODE_LOAD)  ? v : price_t'($urandom());
        o.limit  = (m == MODE_QUERY) ? v : price_t'($urandom());
        order_queue = {order_queue, o};
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, holds each until accepted, and predicts
    // its result at the acceptance edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : order_driver
        order_t nxt;
        sale_t  guess;
        bit     go;
        bit     calm;
        int     i;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                ledger_count[i] = '0;
            end
            live_entries = 0;
            peak_live    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (mode_t'(s_tuser) == MODE_LOAD) begin
                    guess = book_ticket(s_tdata[31:0]);
                    load_items <= load_items + 1;
                end else begin
                    guess = sell_floor(s_tdata[63:32]);
                    query_items <= query_items + 1;
                end
                pending_sales = {pending_sales, guess};
                items_in <= items_in + 1;
            end
            // Slot is free when nothing is offered or the offer was just taken.
            if (!s_tvalid || s_tready) begin
                // Items 250..349 go back to back: no sender idling there.
                calm = (items_in >= 250 && items_in < 350);
                go   = (order_queue.size() != 0) &&
                       (calm || $urandom_range(99) >= IDLE_PCT);
                if (go) begin
                    nxt = order_queue.pop_front();
                    s_tdata  <= {nxt.limit, nxt.ticket};
                    s_tuser  <= nxt.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold-off, and a field check
    // of every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    int hold_left;
    bit hold_done;

    always @(posedge aclk) begin : result_monitor
        sale_t want;
        bit    calm;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_out <= results_out + 1;
                status_seen[m_tuser] <= status_seen[m_tuser] + 1;
                if (pending_sales.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing pending: status %0d sold %h",
                                            m_tuser, m_tdata));
                end else begin
                    want = pending_sales.pop_front();
                    if (m_tuser !== want.status) begin
                        flag_mismatch($sformatf("result %0d status %0d, expected %s",
                                                results_out, m_tuser, want.status.name()));
                    end
                    if (m_tdata !== want.sold) begin
                        flag_mismatch($sformatf("result %0d sold_price %h, expected %h",
                                                results_out, m_tdata, want.sold));
                    end
                end
            end
            // Long hold-off: the block finishes its scan, parks the result, and
            // must then stall the sender, who keeps offering.
            if (!hold_done && results_out == HOLD_AT_RESULT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= (hold_left == 1);
            end else begin
                calm = (items_in >= 250 && items_in < 350);
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: cycles in a row with no handshake on either side.
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d items in, %0d results out",
                     quiet_cycles, items_in, results_out);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : run_control
        price_t price_pool [$];
        price_t v;
        price_t base;
        mode_t  m;
        int     n;
        int     load_pct;

        items_in     = 0;
        results_out  = 0;
        mismatches   = 0;
        load_items   = 0;
        query_items  = 0;
        status_seen  = '{0, 0, 0, 0};

        // Directed: empty-table queries, both price extremes, duplicates,
        // limit exactly on a price, floor between prices, entry reuse.
        push_order(MODE_QUERY, 32'h0000_0000);
        push_order(MODE_QUERY, 32'hFFFF_FFFF);
        push_order(MODE_LOAD,  32'h0000_0000);
        push_order(MODE_LOAD,  32'hFFFF_FFFF);
        push_order(MODE_LOAD,  32'hFFFF_FFFF);
        push_order(MODE_LOAD,  32'd1000);
        push_order(MODE_QUERY, 32'h0000_0000);   // sells the zero price
        push_order(MODE_QUERY, 32'h0000_0000);   // nothing left at zero
        push_order(MODE_QUERY, 32'd999);         // one below a stored price
        push_order(MODE_QUERY, 32'd1000);        // limit equal to the price
        push_order(MODE_QUERY, 32'hFFFF_FFFE);
        push_order(MODE_QUERY, 32'hFFFF_FFFF);   // one of two copies
        push_order(MODE_LOAD,  32'd5);
        push_order(MODE_LOAD,  32'd7);
        push_order(MODE_LOAD,  32'd7);
        push_order(MODE_QUERY, 32'd6);           // floor falls between 5 and 7
        push_order(MODE_QUERY, 32'd100);
        push_order(MODE_QUERY, 32'd100);
        push_order(MODE_QUERY, 32'd100);         // all gone below the limit
        push_order(MODE_LOAD,  32'd42);          // reuses a freed entry
        push_order(MODE_LOAD,  32'hAAAA_AAAA);
        push_order(MODE_LOAD,  32'h5555_5555);
        push_order(MODE_QUERY, 32'h9999_9999);
        push_order(MODE_QUERY, 32'hFFFF_FFFF);
        push_order(MODE_QUERY, 32'hFFFF_FFFF);

        // Random: first half leans on loads to grow the table, second half on
        // queries to drain it. Prices mostly repeat or cluster so that
        // duplicates and exact-limit hits are common.
        for (n = 0; n < RANDOM_ORDERS; n++) begin
            load_pct = (n < RANDOM_ORDERS / 2) ? 65 : 40;
            m = ($urandom_range(99) < load_pct) ? MODE_LOAD : MODE_QUERY;
            base = (price_pool.size() != 0)
                 ? price_pool[$urandom_range(price_pool.size() - 1)] : price_t'($urandom());
            case ($urandom_range(9))
                0, 1, 2: v = base;
                3:       v = ($urandom_range(1) != 0) ? base + 1'b1 : base - 1'b1;
                4, 5:    v = price_t'($urandom_range(63));
                6, 7:    v = price_t'($urandom());
                default: begin
                    case ($urandom_range(3))
                        0:       v = 32'h0000_0000;
                        1:       v = 32'hFFFF_FFFF;
                        2:       v = 32'h8000_0000;
                        default: v = 32'h7FFF_FFFF;
                    endcase
                end
            endcase
            if (m == MODE_LOAD) begin
                price_pool = {price_pool, v};
            end
            push_order(m, v);
        end
        total_orders = order_queue.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_in < total_orders || pending_sales.size() != 0) begin
            @(posedge aclk);
        end
        // Catch any stray result after the last expected one.
        repeat (2 * SCAN_LATENCY) @(posedge aclk);

        $display("Run covered %0d items (%0d loads, %0d queries), peak %0d live entries of %0d.",
                 items_in, load_items, query_items, peak_live, TABLE_DEPTH);
        $display("Results: %0d sold, %0d none within limit, %0d loaded, %0d full; %0d mismatches.",
                 status_seen[STAT_SOLD], status_seen[STAT_NONE], status_seen[STAT_LOADED],
                 status_seen[STAT_FULL], mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
